/* hdl/vhpa_pkg.sv */
// shared types and constants of the voxel hash point accumulator
// no dependencies
`default_nettype none
package vhpa_pkg;
    localparam int TABLE_DEPTH = 131072;
    localparam int MAX_PROBES  = 5;
    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int PROBE_W     = $clog2(MAX_PROBES + 1);

    localparam int PT_W    = 17;
    localparam int KEY_W   = 17;
    localparam int WX_W    = 24;
    localparam int SQ_W    = 48;
    localparam int CNT_W   = 16;
    localparam int SUM_W   = 40;
    localparam int SUM2_W  = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [31:0] HASH_MUL_X = 32'd73856093;
    localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_NEW    = 2'd0,
        ST_MERGED = 2'd1,
        ST_FULL   = 2'd2,
        ST_SAT    = 2'd3
    } vhpa_status_t;

    // item handed from the front to the back through the queue
    typedef struct packed {
        logic signed [KEY_W-1:0] kx;
        logic signed [KEY_W-1:0] ky;
        logic [AW-1:0]           first;
        logic signed [WX_W-1:0]  wx;
        logic signed [WX_W-1:0]  wy;
        logic signed [SQ_W-1:0]  xx;
        logic signed [SQ_W-1:0]  xy;
        logic signed [SQ_W-1:0]  yy;
    } vhpa_item_t;

    typedef struct packed {
        logic [2*KEY_W-1:0]  key;
        logic [CNT_W-1:0]    count;
        logic [SUM_W-1:0]    sx;
        logic [SUM_W-1:0]    sy;
        logic [SUM2_W-1:0]   sxx;
        logic [SUM2_W-1:0]   sxy;
        logic [SUM2_W-1:0]   syy;
    } vhpa_entry_t;

    typedef struct packed {
        logic clearing;
    } vhpa_back_stat_t;
endpackage
`default_nettype wire

/* hdl/vhpa_if.sv */
// point and result channel interfaces
// depends on vhpa_pkg
`default_nettype none
interface vhpa_point_if
    import vhpa_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    modport source (output valid, output point_x, output point_y, input ready);
    modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface vhpa_result_if
    import vhpa_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [AW-1:0]           slot;
    logic signed [KEY_W-1:0] key_x;
    logic signed [KEY_W-1:0] key_y;
    logic [CNT_W-1:0]        point_count;
    modport source (output valid, output status, output slot, output key_x,
                    output key_y, output point_count, input ready);
    modport sink (input valid, input status, input slot, input key_x,
                  input key_y, input point_count, output ready);
endinterface
`default_nettype wire

/* hdl/vhpa_ram.sv */
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module vhpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* hdl/vhpa_front.sv */
// front: pose registers, transform, quantize and hash pipeline
// depends on vhpa_pkg and vhpa_if
`default_nettype none
module vhpa_front
    import vhpa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    vhpa_point_if.sink                 point,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire vhpa_back_stat_t       stat,
    output logic                       q_valid,
    output vhpa_item_t                 q_item,
    input  wire logic                  q_ready
);
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_COS = 3'd0,
        CFG_ROT_SIN = 3'd1,
        CFG_TRANS_X = 3'd2,
        CFG_TRANS_Y = 3'd3,
        CFG_INV_VOX = 3'd4
    } cfg_idx_t;

    localparam int P_W = 33;
    localparam int D_W = 34;
    localparam int M_W = 46;
    localparam int Q_W = 20;

    logic signed [15:0] cos_reg, sin_reg;
    logic signed [21:0] tx_reg, ty_reg;
    logic [20:0]        inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= 16'sd16384;
            sin_reg <= '0;
            tx_reg  <= '0;
            ty_reg  <= '0;
            inv_reg <= 21'd327680;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROT_COS: cos_reg <= cfg_data[15:0];
                CFG_ROT_SIN: sin_reg <= cfg_data[15:0];
                CFG_TRANS_X: tx_reg  <= cfg_data[21:0];
                CFG_TRANS_Y: ty_reg  <= cfg_data[21:0];
                CFG_INV_VOX: inv_reg <= cfg_data[20:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [KEY_W-1:0] sat_key(input logic signed [Q_W-1:0] q);
        logic signed [KEY_W-1:0] k;
        if (q > Q_W'(65535))
        begin
            k = KEY_W'(65535);
        end
        else if (q < -Q_W'(65536))
        begin
            k = KEY_W'(-65536);
        end
        else
        begin
            k = KEY_W'(q);
        end
        return k;
    endfunction

    logic [4:0] v_reg;
    logic       advance;

    assign advance     = !(v_reg[4] && !q_ready);
    assign point.ready = advance && !stat.clearing;

    logic signed [P_W-1:0]  pcx_reg, psy_reg, psx_reg, pcy_reg;
    logic signed [WX_W-1:0] wx2_reg, wy2_reg;
    logic signed [M_W-1:0]  mx_reg, my_reg;
    logic signed [WX_W-1:0] wx3_reg, wy3_reg, wx4_reg, wy4_reg, wx5_reg, wy5_reg;
    logic signed [SQ_W-1:0] xx3_reg, xy3_reg, yy3_reg;
    logic signed [SQ_W-1:0] xx4_reg, xy4_reg, yy4_reg, xx5_reg, xy5_reg, yy5_reg;
    logic signed [KEY_W-1:0] kx4_reg, ky4_reg, kx5_reg, ky5_reg;
    logic [31:0]            hx_reg, hy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[3:0], point.valid && point.ready};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pcx_reg <= P_W'(cos_reg) * P_W'(point.point_x);
            psy_reg <= P_W'(sin_reg) * P_W'(point.point_y);
            psx_reg <= P_W'(sin_reg) * P_W'(point.point_x);
            pcy_reg <= P_W'(cos_reg) * P_W'(point.point_y);

            wx2_reg <= WX_W'((D_W'(pcx_reg) - D_W'(psy_reg)) >>> 14) + WX_W'(tx_reg);
            wy2_reg <= WX_W'((D_W'(psx_reg) + D_W'(pcy_reg)) >>> 14) + WX_W'(ty_reg);

            mx_reg  <= M_W'(wx2_reg) * M_W'($signed({1'b0, inv_reg}));
            my_reg  <= M_W'(wy2_reg) * M_W'($signed({1'b0, inv_reg}));
            xx3_reg <= SQ_W'(wx2_reg) * SQ_W'(wx2_reg);
            xy3_reg <= SQ_W'(wx2_reg) * SQ_W'(wy2_reg);
            yy3_reg <= SQ_W'(wy2_reg) * SQ_W'(wy2_reg);
            wx3_reg <= wx2_reg;
            wy3_reg <= wy2_reg;

            kx4_reg <= sat_key(Q_W'(mx_reg >>> 26));
            ky4_reg <= sat_key(Q_W'(my_reg >>> 26));
            wx4_reg <= wx3_reg;
            wy4_reg <= wy3_reg;
            xx4_reg <= xx3_reg;
            xy4_reg <= xy3_reg;
            yy4_reg <= yy3_reg;

            hx_reg  <= 32'(kx4_reg) * HASH_MUL_X;
            hy_reg  <= 32'(ky4_reg) * HASH_MUL_Y;
            kx5_reg <= kx4_reg;
            ky5_reg <= ky4_reg;
            wx5_reg <= wx4_reg;
            wy5_reg <= wy4_reg;
            xx5_reg <= xx4_reg;
            xy5_reg <= xy4_reg;
            yy5_reg <= yy4_reg;
        end
    end

    logic [31:0] hash;
    assign hash = hx_reg ^ hy_reg;

    assign q_valid      = v_reg[4];
    assign q_item.kx    = kx5_reg;
    assign q_item.ky    = ky5_reg;
    assign q_item.first = hash[AW-1:0];
    assign q_item.wx    = wx5_reg;
    assign q_item.wy    = wy5_reg;
    assign q_item.xx    = xx5_reg;
    assign q_item.xy    = xy5_reg;
    assign q_item.yy    = yy5_reg;
endmodule
`default_nettype wire

/* hdl/vhpa_fifo.sv */
// short queue between front and back
// depends on vhpa_pkg
`default_nettype none
module vhpa_fifo
    import vhpa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    input  wire vhpa_item_t push_item,
    output logic            push_ready,
    output logic            pop_valid,
    output vhpa_item_t      pop_item,
    input  wire logic       pop
);
    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    vhpa_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [PTR_W:0]   cnt_reg;
    logic             do_push, do_pop;

    assign push_ready = cnt_reg != (PTR_W+1)'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

/* hdl/vhpa_back.sv */
// back: probe sequencer over the slot table, accumulation and result register
// depends on vhpa_pkg, vhpa_if and vhpa_ram
`default_nettype none
module vhpa_back
    import vhpa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire vhpa_item_t q_item,
    output logic            q_pop,
    output vhpa_back_stat_t stat,
    vhpa_result_if.source   result
);
    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_READ  = 4'b0100,
        B_CHECK = 4'b1000
    } bstate_t;

    bstate_t             state_reg, state_next;
    logic [AW-1:0]       clr_reg;
    vhpa_item_t          cur_reg;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [PROBE_W-1:0]  probe_reg, probe_next;

    logic                res_valid_reg;
    vhpa_status_t        res_status_reg, res_status_next;
    logic [AW-1:0]       res_slot_reg, res_slot_next;
    logic [CNT_W-1:0]    res_cnt_reg, res_cnt_next;
    logic signed [KEY_W-1:0] res_kx_reg, res_ky_reg;

    logic          vld_we, vld_wdata, vld_rd;
    logic [AW-1:0] vld_addr, ram_addr;
    logic          dat_we;
    vhpa_entry_t   dat_wdata, dat_rd;

    vhpa_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_valid_ram (
        .clk   (clk),
        .we    (vld_we),
        .addr  (vld_addr),
        .wdata (vld_wdata),
        .rdata (vld_rd)
    );

    vhpa_ram #(.WIDTH($bits(vhpa_entry_t)), .DEPTH(TABLE_DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (dat_we),
        .addr  (ram_addr),
        .wdata (dat_wdata),
        .rdata (dat_rd)
    );

    logic [2*KEY_W-1:0] cur_key;
    logic out_free, hit, sat, last_probe, done;

    assign cur_key    = {cur_reg.ky, cur_reg.kx};
    assign out_free   = !res_valid_reg || result.ready;
    assign hit        = vld_rd && (dat_rd.key == cur_key);
    assign sat        = dat_rd.count == COUNT_MAX;
    assign last_probe = probe_reg == PROBE_W'(MAX_PROBES - 1);
    assign stat.clearing = state_reg == B_CLEAR;

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        probe_next      = probe_reg;
        q_pop           = 1'b0;
        vld_we          = 1'b0;
        vld_wdata       = 1'b0;
        vld_addr        = addr_reg;
        ram_addr        = addr_reg;
        dat_we          = 1'b0;
        done            = 1'b0;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_cnt_next    = res_cnt_reg;
        dat_wdata.key   = cur_key;
        dat_wdata.count = CNT_W'(1);
        dat_wdata.sx    = SUM_W'(cur_reg.wx);
        dat_wdata.sy    = SUM_W'(cur_reg.wy);
        dat_wdata.sxx   = SUM2_W'(cur_reg.xx);
        dat_wdata.sxy   = SUM2_W'(cur_reg.xy);
        dat_wdata.syy   = SUM2_W'(cur_reg.yy);
        case (state_reg)
            B_CLEAR:
            begin
                vld_addr = clr_reg;
                vld_we   = 1'b1;
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    addr_next  = q_item.first;
                    probe_next = '0;
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if (vld_rd && !hit && !last_probe)
                begin
                    // collision, move on to the next slot
                    addr_next  = addr_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    vld_addr   = addr_next;
                    ram_addr   = addr_next;
                end
                else if (out_free)
                begin
                    done          = 1'b1;
                    state_next    = B_IDLE;
                    res_slot_next = addr_reg;
                    if (!vld_rd)
                    begin
                        vld_we          = 1'b1;
                        vld_wdata       = 1'b1;
                        dat_we          = 1'b1;
                        res_status_next = ST_NEW;
                        res_cnt_next    = CNT_W'(1);
                    end
                    else if (hit && sat)
                    begin
                        res_status_next = ST_SAT;
                        res_cnt_next    = COUNT_MAX;
                    end
                    else if (hit)
                    begin
                        dat_we          = 1'b1;
                        dat_wdata.count = dat_rd.count + 1'b1;
                        dat_wdata.sx    = dat_rd.sx + SUM_W'(cur_reg.wx);
                        dat_wdata.sy    = dat_rd.sy + SUM_W'(cur_reg.wy);
                        dat_wdata.sxx   = dat_rd.sxx + SUM2_W'(cur_reg.xx);
                        dat_wdata.sxy   = dat_rd.sxy + SUM2_W'(cur_reg.xy);
                        dat_wdata.syy   = dat_rd.syy + SUM2_W'(cur_reg.yy);
                        res_status_next = ST_MERGED;
                        res_cnt_next    = dat_rd.count + 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                        res_slot_next   = cur_reg.first;
                        res_cnt_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
            probe_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            probe_reg <= probe_next;
            if (state_reg == B_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (done)
        begin
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_cnt_reg    <= res_cnt_next;
            res_kx_reg     <= cur_reg.kx;
            res_ky_reg     <= cur_reg.ky;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.status      = res_status_reg;
    assign result.slot        = res_slot_reg;
    assign result.key_x       = res_kx_reg;
    assign result.key_y       = res_ky_reg;
    assign result.point_count = res_cnt_reg;

`ifndef SYNTHESIS
    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CLEAR |-> !q_pop)
        else $error("queue popped during clearing pass");
    a_write_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        dat_we |-> (state_reg == B_CHECK) && out_free)
        else $error("table write outside a completing probe");
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        probe_reg < PROBE_W'(MAX_PROBES))
        else $error("probe count beyond limit");
    a_full_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_status_reg == ST_FULL |-> res_cnt_reg == '0)
        else $error("dropped point reports nonzero count");
    a_done_frees_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == B_IDLE && res_valid_reg)
        else $error("finished probe did not post a result");
`endif
endmodule
`default_nettype wire

/* hdl/voxel_hash_point_accumulator.sv */
// voxel hash point accumulator top level: front pipeline, queue, probe back end
// path: transform and hash pipeline, the queue, then the back end's read and check states
// the back end takes one point at a time, with serial probe reads
//   of the single-port slot table, and a full result register stalls it
// reset: pose registers take their reset values; a clearing pass over all TABLE_DEPTH
//   slots zeroes the slot valid bits, points are not accepted until it ends
// depends on vhpa_pkg, vhpa_if, vhpa_ram, vhpa_front, vhpa_fifo, vhpa_back
`default_nettype none
module voxel_hash_point_accumulator
    import vhpa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    vhpa_point_if.sink                 point,
    vhpa_result_if.source              result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    vhpa_back_stat_t stat;
    logic            f_valid, f_ready, b_valid, b_pop;
    vhpa_item_t      f_item, b_item;

    vhpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .q_valid   (f_valid),
        .q_item    (f_item),
        .q_ready   (f_ready)
    );

    vhpa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_item  (f_item),
        .push_ready (f_ready),
        .pop_valid  (b_valid),
        .pop_item   (b_item),
        .pop        (b_pop)
    );

    vhpa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_item  (b_item),
        .q_pop   (b_pop),
        .stat    (stat),
        .result  (result)
    );
endmodule
`default_nettype wire
